// ----- rtl/esc_pkg.sv -----
// Shared types and constants for the elevator sweep controller.
package esc_pkg;

    // Travel direction; the request table stores the same codes (stop means no request).
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } esc_dir_t;

    localparam logic       FUNC_PRESS      = 1'b0;
    localparam logic       FUNC_PASS       = 1'b1;

    localparam logic [3:0] BTN_CALL_LIMIT  = 4'd10;
    localparam logic [3:0] BTN_DOOR        = 4'd10;
    localparam logic [3:0] BTN_ALARM       = 4'd11;
    localparam logic [3:0] BTN_ON          = 4'd12;
    localparam logic [3:0] BTN_OFF         = 4'd13;

    typedef struct packed {
        logic       func;
        logic [3:0] button;
    } esc_req_t;

    typedef struct packed {
        logic [3:0] floor_now;
        logic       door_open;
        logic       running;
        logic       alarm_on;
        logic       last;
    } esc_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic press;
        logic pass_init;
        logic scan;
        logic door_close;
        logic travel;
        logic shut;
        logic emit;
        logic last;
    } esc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic scan_end;
        logic hit;
        logic at_target;
    } esc_stat_t;

endpackage

// ----- rtl/elevator_sweep_controller.sv -----
// Top level of the elevator sweep controller: controller plus datapath.
//
// The block serves an elevator of FLOORS floors (10 by default). A request is taken at a
// rising clock edge where start is high and busy is low; busy stays high until the last
// result of that request has been issued, and one more request may be accepted in the
// cycle in which that last result is on the ports. Results appear on result for exactly
// one cycle, flagged by result_strobe; the receiver cannot stall them, so it must take
// every strobe. A button request yields one result, set up by the press state and held in
// the result register. A service pass first checks the car state, then steps through every
// floor in the travel direction up to the end of the shaft, and for every floor where a
// matching request is served it issues one door-close result, one result per floor moved,
// one door-open result and one door-close result, each under a strobe of its own; the scan
// is a single floor pointer stepped by the state machine. The pass ends with a status
// result flagged last. Results inside a pass may be separated by idle cycles while the
// scan walks past floors with no matching request.
module elevator_sweep_controller
    import esc_pkg::*;
#(
    parameter int FLOORS = 10
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  esc_req_t request,
    output esc_res_t result,
    output logic     result_strobe
);

    // Command and status buses between the sequencer and the datapath.
    esc_cmd_t  cmd;
    esc_stat_t stat;

    // The sequencer picks the button path or the service pass from the request's func bit
    // in the acceptance cycle, then steps the datapath one action per cycle.
    esc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (request.func),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // The datapath holds the per-floor request table, car position, direction, door,
    // run and alarm flags, and registers each result as it is issued.
    esc_dp #(
        .FLOORS (FLOORS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

// ----- rtl/esc_ctrl.sv -----
// Sequencing state machine for the elevator sweep controller.
module esc_ctrl
    import esc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      func,
    input  esc_stat_t stat,
    output logic      busy,
    output esc_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PRESS = 7'b0000010,
        S_PASS  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_CLOSE = 7'b0010000,
        S_MOVE  = 7'b0100000,
        S_SHUT  = 7'b1000000
    } esc_state_t;

    esc_state_t state_reg;
    esc_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (func == FUNC_PASS) ? S_PASS : S_PRESS;
                end
            end
            S_PRESS:
            begin
                cmd.press  = 1'b1;
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            S_PASS:
            begin
                if (stat.active)
                begin
                    cmd.pass_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_end)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.hit)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.door_close = 1'b1;
                cmd.emit       = 1'b1;
                state_next     = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.travel = 1'b1;
                cmd.emit   = 1'b1;
                if (stat.at_target)
                begin
                    state_next = S_SHUT;
                end
            end
            S_SHUT:
            begin
                cmd.shut   = 1'b1;
                cmd.emit   = 1'b1;
                state_next = S_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_start_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_PRESS || state_reg == S_PASS))
        else $error("accepted request did not dispatch");

    a_shut_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHUT) |=> (state_reg == S_SCAN))
        else $error("served stop did not resume the scan");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> !busy)
        else $error("final result did not return to idle");

endmodule

// ----- rtl/esc_dp.sv -----
// Datapath: request table, car state, scan pointer and result register.
module esc_dp
    import esc_pkg::*;
#(
    parameter int FLOORS = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  esc_req_t  request,
    input  esc_cmd_t  cmd,
    output esc_stat_t stat,
    output esc_res_t  result,
    output logic      result_strobe
);

    localparam int FW = (FLOORS > 2) ? $clog2(FLOORS) : 1;

    esc_dir_t        req_reg  [FLOORS];
    esc_dir_t        req_next [FLOORS];
    logic [FW-1:0]   floor_reg, floor_next;
    logic [FW-1:0]   x_reg, x_next;
    esc_dir_t        dir_reg, dir_next;
    logic            door_reg, door_next;
    logic            run_reg, run_next;
    logic            alarm_reg, alarm_next;
    logic [3:0]      btn_reg;
    esc_res_t        result_reg;
    logic            strobe_reg;

    logic [FW-1:0]   x_adv;
    logic [FW-1:0]   look_idx;
    logic [FW-1:0]   call_idx;
    logic            call_ok;

    // Scan neighbor in the travel direction, end-of-shaft detection, status flags and call check.
    always_comb
    begin
        x_adv         = (dir_reg == DIR_UP) ? x_reg + FW'(1) : x_reg - FW'(1);
        stat.scan_end = (dir_reg == DIR_UP) ? ((5'(x_reg) + 5'd1) >= 5'(FLOORS))
                                            : (x_reg == '0);
        look_idx      = stat.scan_end ? x_reg : x_adv;
        stat.hit      = !stat.scan_end && (req_reg[look_idx] == dir_reg);
        stat.active   = run_reg && (dir_reg != DIR_STOP);
        stat.at_target = (floor_reg == x_reg);
        call_idx      = btn_reg[FW-1:0];
        call_ok       = (btn_reg < BTN_CALL_LIMIT) && ({1'b0, btn_reg} < 5'(FLOORS)) && run_reg;
    end

    always_comb
    begin
        req_next   = req_reg;
        floor_next = floor_reg;
        x_next     = x_reg;
        dir_next   = dir_reg;
        door_next  = door_reg;
        run_next   = run_reg;
        alarm_next = alarm_reg;

        if (cmd.press)
        begin
            if (btn_reg < BTN_CALL_LIMIT)
            begin
                if (call_ok)
                begin
                    if (4'(floor_reg) > btn_reg)
                    begin
                        req_next[call_idx] = DIR_DOWN;
                        dir_next           = DIR_DOWN;
                    end
                    else if (4'(floor_reg) < btn_reg)
                    begin
                        req_next[call_idx] = DIR_UP;
                        dir_next           = DIR_UP;
                    end
                end
            end
            else
            begin
                unique case (btn_reg)
                    BTN_DOOR:
                    begin
                        door_next = !door_reg;
                    end
                    BTN_ALARM:
                    begin
                        alarm_next = !alarm_reg;
                        run_next   = alarm_reg;
                    end
                    BTN_ON, BTN_OFF:
                    begin
                        if (btn_reg == BTN_ON && !run_reg)
                        begin
                            run_next  = 1'b1;
                            door_next = 1'b1;
                        end
                        if (btn_reg == BTN_OFF && run_reg)
                        begin
                            run_next  = 1'b0;
                            door_next = 1'b0;
                        end
                        for (int i = 0; i < FLOORS; i++)
                        begin
                            req_next[i] = DIR_STOP;
                        end
                        floor_next = '0;
                        dir_next   = DIR_STOP;
                        alarm_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (cmd.pass_init)
        begin
            x_next = floor_reg;
            if (floor_reg == '0)
            begin
                dir_next = DIR_UP;
            end
            if (5'(floor_reg) == 5'(FLOORS - 1))
            begin
                dir_next = DIR_DOWN;
            end
        end

        if (cmd.scan)
        begin
            if (stat.scan_end)
            begin
                dir_next = DIR_STOP;
                run_next = 1'b1;
            end
            else
            begin
                x_next = x_adv;
                if (!stat.hit)
                begin
                    req_next[x_adv] = DIR_STOP;
                end
            end
        end

        if (cmd.door_close)
        begin
            door_next = 1'b0;
        end

        if (cmd.travel)
        begin
            if (floor_reg < x_reg)
            begin
                floor_next = floor_reg + FW'(1);
            end
            else if (floor_reg > x_reg)
            begin
                floor_next = floor_reg - FW'(1);
            end
            else
            begin
                door_next = 1'b1;
            end
        end

        if (cmd.shut)
        begin
            door_next      = 1'b0;
            req_next[x_reg] = DIR_STOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FLOORS; i++)
            begin
                req_reg[i] <= DIR_STOP;
            end
            floor_reg  <= '0;
            dir_reg    <= DIR_STOP;
            door_reg   <= 1'b1;
            run_reg    <= 1'b0;
            alarm_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            req_reg    <= req_next;
            floor_reg  <= floor_next;
            dir_reg    <= dir_next;
            door_reg   <= door_next;
            run_reg    <= run_next;
            alarm_reg  <= alarm_next;
            strobe_reg <= cmd.emit;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (cmd.load)
        begin
            btn_reg <= request.button;
        end
        if (cmd.emit)
        begin
            result_reg.floor_now <= 4'(floor_next);
            result_reg.door_open <= door_next;
            result_reg.running   <= run_next;
            result_reg.alarm_on  <= alarm_next;
            result_reg.last      <= cmd.last;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
        5'(floor_reg) < 5'(FLOORS))
        else $error("car floor out of range");

    a_pass_running: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !result_reg.last) |-> run_reg)
        else $error("service result while not running");

    a_move_door_shut: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.travel && (floor_reg != x_reg)) |-> !door_reg)
        else $error("car moving with the door open");

endmodule
